// ===== hw/rtl/ubxfr_pkg.sv =====
// ubxfr_pkg: shared types and constants for the UBX frame receiver.
// Used by ubxfr_core and ubx_frame_receiver_top; no dependencies.
package ubxfr_pkg;

    localparam int MAX_PAYLOAD = 256;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd2000;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_ARM  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HEADER   = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic [1:0] CFG_CLASS   = 2'd0;
    localparam logic [1:0] CFG_ID      = 2'd1;
    localparam logic [1:0] CFG_LENGTH  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [7:0]  hdr_class;
        logic [7:0]  exp_id;
        logic [8:0]  exp_length;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [7:0]  index;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== hw/rtl/ubx_frame_receiver_top.sv =====
// ubx_frame_receiver_top: configuration registers, parser core, output register + skid.
// Depends on ubxfr_pkg and ubxfr_core.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   req_type, rx_byte
//  out      source     out_valid/out_stall result_kind, data_byte, byte_index, status
//  cfg      sink       cfg_we              cfg_index, cfg_data
//
// One beat accepted per cycle while in_stall is low; each result is registered in the
// output register, or in the skid entry when out is stalled. The parser core is
// combinational between the in port and the output register. Output register plus
// one skid entry: in_stall rises only when the skid entry is occupied. Reset returns
// the parser to idle and the registers to their defaults.
module ubx_frame_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ubxfr_pkg::cfg_t    cfg_reg;
    ubxfr_pkg::result_t out_reg,  skid_reg;
    ubxfr_pkg::result_t core_res;
    logic               out_valid_reg, skid_valid_reg;
    logic               core_valid;
    logic               accept;
    logic               out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hdr_class     <= 8'd1;
            cfg_reg.exp_id        <= 8'd3;
            cfg_reg.exp_length    <= 9'd16;
            cfg_reg.timeout_ticks <= ubxfr_pkg::DEFAULT_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ubxfr_pkg::CFG_CLASS:   cfg_reg.hdr_class     <= cfg_data[7:0];
                ubxfr_pkg::CFG_ID:      cfg_reg.exp_id        <= cfg_data[7:0];
                ubxfr_pkg::CFG_LENGTH:  cfg_reg.exp_length    <= cfg_data[8:0];
                ubxfr_pkg::CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
            endcase
        end
    end

    ubxfr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (core_valid)
        begin
            if (out_free)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
                out_reg <= skid_reg;
        end
        else if (core_valid)
        begin
            if (out_free)
                out_reg <= core_res;
            else
                skid_reg <= core_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_reg.kind;
    assign data_byte   = out_reg.data;
    assign byte_index  = out_reg.index;
    assign status      = out_reg.status;

endmodule

// ===== hw/rtl/ubxfr_core.sv =====
// ubxfr_core: frame parser state, Fletcher sums, header/checksum/timeout checks.
// One beat per cycle while accept is high; produces at most one result per beat. Depends on ubxfr_pkg.
module ubxfr_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          req_type,
    input  logic [7:0]          rx_byte,
    input  ubxfr_pkg::cfg_t     cfg,
    output logic                res_valid,
    output ubxfr_pkg::result_t  res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HUNT    = 4'd1;
    localparam logic [3:0] PH_SYNC2   = 4'd2;
    localparam logic [3:0] PH_CLASS   = 4'd3;
    localparam logic [3:0] PH_ID      = 4'd4;
    localparam logic [3:0] PH_LEN_LO  = 4'd5;
    localparam logic [3:0] PH_LEN_HI  = 4'd6;
    localparam logic [3:0] PH_PAYLOAD = 4'd7;
    localparam logic [3:0] PH_CK_A    = 4'd8;
    localparam logic [3:0] PH_CK_B    = 4'd9;

    logic [3:0]  phase_reg,    phase_next;
    logic [7:0]  sum_a_reg,    sum_a_next;
    logic [7:0]  sum_b_reg,    sum_b_next;
    logic [8:0]  count_reg,    count_next;
    logic [15:0] elapsed_reg,  elapsed_next;
    logic [7:0]  len_lo_reg,   len_lo_next;
    logic [8:0]  decl_len_reg, decl_len_next;
    logic        hdr_ok_reg,   hdr_ok_next;
    logic        ck_a_ok_reg,  ck_a_ok_next;

    logic [7:0]  sa_add;
    logic [7:0]  sb_add;
    logic [15:0] elapsed_inc;
    logic [15:0] full_len;
    logic [8:0]  count_inc;
    logic        hdr_bad;

    assign sa_add      = sum_a_reg + rx_byte;
    assign sb_add      = sum_b_reg + sa_add;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign full_len    = {rx_byte, len_lo_reg};
    assign count_inc   = count_reg + 9'd1;
    assign hdr_bad     = !hdr_ok_reg
                       || (full_len != {7'd0, cfg.exp_length})
                       || ({7'd0, cfg.exp_length} > 16'(ubxfr_pkg::MAX_PAYLOAD));

    always_comb
    begin
        phase_next    = phase_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        count_next    = count_reg;
        elapsed_next  = elapsed_reg;
        len_lo_next   = len_lo_reg;
        decl_len_next = decl_len_reg;
        hdr_ok_next   = hdr_ok_reg;
        ck_a_ok_next  = ck_a_ok_reg;
        res_valid     = 1'b0;
        res.kind      = ubxfr_pkg::KIND_DONE;
        res.data      = 8'd0;
        res.index     = 8'd0;
        res.status    = ubxfr_pkg::ST_OK;

        if (accept)
        begin
            if (req_type == ubxfr_pkg::REQ_ARM)
            begin
                phase_next    = PH_HUNT;
                sum_a_next    = 8'd0;
                sum_b_next    = 8'd0;
                count_next    = 9'd0;
                elapsed_next  = 16'd0;
                len_lo_next   = 8'd0;
                decl_len_next = 9'd0;
                hdr_ok_next   = 1'b0;
                ck_a_ok_next  = 1'b0;
            end
            else if (phase_reg == PH_IDLE)
            begin
                phase_next = PH_IDLE;
            end
            else if (req_type == ubxfr_pkg::REQ_TICK)
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= cfg.timeout_ticks)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res.status = ubxfr_pkg::ST_TIMEOUT;
                end
            end
            else if (req_type == ubxfr_pkg::REQ_BYTE)
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == ubxfr_pkg::SYNC_FIRST)
                            phase_next = PH_SYNC2;
                    end
                    PH_SYNC2:
                    begin
                        if (rx_byte == ubxfr_pkg::SYNC_SECOND)
                            phase_next = PH_CLASS;
                        else if (rx_byte != ubxfr_pkg::SYNC_FIRST)
                            phase_next = PH_HUNT;
                    end
                    PH_CLASS:
                    begin
                        sum_a_next  = sa_add;
                        sum_b_next  = sb_add;
                        hdr_ok_next = (rx_byte == cfg.hdr_class);
                        phase_next  = PH_ID;
                    end
                    PH_ID:
                    begin
                        sum_a_next  = sa_add;
                        sum_b_next  = sb_add;
                        hdr_ok_next = hdr_ok_reg && (rx_byte == cfg.exp_id);
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        sum_a_next  = sa_add;
                        sum_b_next  = sb_add;
                        len_lo_next = rx_byte;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        sum_a_next    = sa_add;
                        sum_b_next    = sb_add;
                        decl_len_next = full_len[8:0];
                        if (hdr_bad)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.status = ubxfr_pkg::ST_HEADER;
                        end
                        else
                        begin
                            count_next = 9'd0;
                            phase_next = (full_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        sum_a_next = sa_add;
                        sum_b_next = sb_add;
                        res_valid  = 1'b1;
                        res.kind   = ubxfr_pkg::KIND_PAYLOAD;
                        res.data   = rx_byte;
                        res.index  = count_reg[7:0];
                        count_next = count_inc;
                        if (count_inc >= decl_len_reg)
                            phase_next = PH_CK_A;
                    end
                    PH_CK_A:
                    begin
                        ck_a_ok_next = (rx_byte == sum_a_reg);
                        phase_next   = PH_CK_B;
                    end
                    PH_CK_B:
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.status = (ck_a_ok_reg && rx_byte == sum_b_reg)
                                   ? ubxfr_pkg::ST_OK : ubxfr_pkg::ST_CHECKSUM;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            sum_a_reg    <= 8'd0;
            sum_b_reg    <= 8'd0;
            count_reg    <= 9'd0;
            elapsed_reg  <= 16'd0;
            len_lo_reg   <= 8'd0;
            decl_len_reg <= 9'd0;
            hdr_ok_reg   <= 1'b0;
            ck_a_ok_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            count_reg    <= count_next;
            elapsed_reg  <= elapsed_next;
            len_lo_reg   <= len_lo_next;
            decl_len_reg <= decl_len_next;
            hdr_ok_reg   <= hdr_ok_next;
            ck_a_ok_reg  <= ck_a_ok_next;
        end
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for ubx_frame_receiver_top: directed frames from a table, then
// random frames and noise under random valid/stall gaps, checked against a frame predictor.
// Depends on ubxfr_pkg and ubx_frame_receiver_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ubxfr_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1650;
    localparam int RANDOM_PHASES = 8;

    typedef enum logic [3:0]
    {
        PS_IDLE, PS_HUNT, PS_SYNC2, PS_CLASS, PS_ID,
        PS_LEN_LO, PS_LEN_HI, PS_PAYLOAD, PS_CK_A, PS_CK_B
    } parse_phase_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  req;
        logic [7:0]  data;
        logic        pinned;
        logic [1:0]  st;
        cfg_t        cfg;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [1:0]  status;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_CLASS;
    logic [15:0] cfg_data = 16'h0000;

    // predictor state and its copy of the registers
    cfg_t         frame_cfg;
    parse_phase_t parse_phase;
    logic [7:0]   sum_a;
    logic [7:0]   sum_b;
    logic [8:0]   pay_count;
    logic [15:0]  tick_count;
    logic [15:0]  decl_len;
    logic         hdr_match;
    logic         ck_a_match;

    result_t due_results[$];
    int      mismatches = 0;
    int      live_items = 0;
    int      quiet_cycles = 0;
    int      hold_left = 0;
    bit      hold_request = 1'b0;
    bit      hold_done = 1'b0;
    bit      calm = 1'b0;

    ubx_frame_receiver_top i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void clear_parser();
        parse_phase = PS_IDLE;
        sum_a = 8'h00;
        sum_b = 8'h00;
        pay_count = 9'd0;
        tick_count = 16'd0;
        decl_len = 16'd0;
        hdr_match = 1'b0;
        ck_a_match = 1'b0;
    endfunction

    function automatic void fold_sum(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endfunction

    function automatic bit advance_parser(input logic [1:0] req, input logic [7:0] b,
                                          output result_t r);
        bit         finished;
        logic [1:0] st;
        finished = 1'b0;
        st = ST_OK;
        r = '0;
        if (req == REQ_ARM)
        begin
            clear_parser();
            parse_phase = PS_HUNT;
            return 1'b0;
        end
        if (parse_phase == PS_IDLE || req == REQ_UNUSED)
            return 1'b0;
        if (req == REQ_TICK)
        begin
            if (tick_count != 16'hFFFF)
                tick_count = tick_count + 16'd1;
            finished = (tick_count >= frame_cfg.timeout_ticks);
            st = ST_TIMEOUT;
        end
        else
        begin
            case (parse_phase)
                PS_HUNT:
                begin
                    if (b == SYNC_FIRST)
                        parse_phase = PS_SYNC2;
                end
                PS_SYNC2:
                begin
                    if (b == SYNC_SECOND)
                        parse_phase = PS_CLASS;
                    else if (b != SYNC_FIRST)
                        parse_phase = PS_HUNT;
                end
                PS_CLASS:
                begin
                    fold_sum(b);
                    hdr_match = (b == frame_cfg.hdr_class);
                    parse_phase = PS_ID;
                end
                PS_ID:
                begin
                    fold_sum(b);
                    hdr_match = hdr_match && (b == frame_cfg.exp_id);
                    parse_phase = PS_LEN_LO;
                end
                PS_LEN_LO:
                begin
                    fold_sum(b);
                    decl_len = {8'h00, b};
                    parse_phase = PS_LEN_HI;
                end
                PS_LEN_HI:
                begin
                    fold_sum(b);
                    decl_len[15:8] = b;
                    if (!hdr_match || decl_len != {7'd0, frame_cfg.exp_length} ||
                        frame_cfg.exp_length > MAX_PAYLOAD)
                    begin
                        finished = 1'b1;
                        st = ST_HEADER;
                    end
                    else
                    begin
                        pay_count = 9'd0;
                        if (decl_len == 16'd0)
                            parse_phase = PS_CK_A;
                        else
                            parse_phase = PS_PAYLOAD;
                    end
                end
                PS_PAYLOAD:
                begin
                    fold_sum(b);
                    r.kind = KIND_PAYLOAD;
                    r.data = b;
                    r.index = pay_count[7:0];
                    r.status = ST_OK;
                    pay_count = pay_count + 9'd1;
                    if ({7'd0, pay_count} >= decl_len)
                        parse_phase = PS_CK_A;
                    return 1'b1;
                end
                PS_CK_A:
                begin
                    ck_a_match = (b == sum_a);
                    parse_phase = PS_CK_B;
                end
                PS_CK_B:
                begin
                    finished = 1'b1;
                    st = (ck_a_match && b == sum_b) ? ST_OK : ST_CHECKSUM;
                end
                default:
                    parse_phase = PS_IDLE;
            endcase
        end
        if (finished)
        begin
            parse_phase = PS_IDLE;
            r.kind = KIND_DONE;
            r.status = st;
        end
        return finished;
    endfunction

    function automatic directed_row_t beat_row(input logic [1:0] req, input logic [7:0] b);
        directed_row_t row;
        row = '0;
        row.kind = ROW_BEAT;
        row.req = req;
        row.data = b;
        return row;
    endfunction

    function automatic directed_row_t done_row(input logic [1:0] req, input logic [7:0] b,
                                               input logic [1:0] st);
        directed_row_t row;
        row = beat_row(req, b);
        row.pinned = 1'b1;
        row.st = st;
        return row;
    endfunction

    function automatic directed_row_t cfg_row(input logic [7:0] cls, input logic [7:0] id,
                                              input logic [8:0] len, input logic [15:0] ticks);
        directed_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.cfg.hdr_class = cls;
        row.cfg.exp_id = id;
        row.cfg.exp_length = len;
        row.cfg.timeout_ticks = ticks;
        return row;
    endfunction

    task automatic offer_beat(input logic [1:0] req, input logic [7:0] b,
                              input logic pinned, input logic [1:0] pinned_st);
        result_t r;
        result_t fixed;
        bit      got;
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        live_items++;
        got = advance_parser(req, b, r);
        if (pinned)
        begin
            fixed = '0;
            fixed.kind = KIND_DONE;
            fixed.status = pinned_st;
            due_results.push_back(fixed);
        end
        else if (got)
            due_results.push_back(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input cfg_t c);
        frame_cfg = c;
        cfg_we <= 1'b1;
        cfg_index <= CFG_CLASS;
        cfg_data <= {8'h00, c.hdr_class};
        @(posedge clk);
        cfg_index <= CFG_ID;
        cfg_data <= {8'h00, c.exp_id};
        @(posedge clk);
        cfg_index <= CFG_LENGTH;
        cfg_data <= {7'd0, c.exp_length};
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data <= c.timeout_ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one arm plus a frame, mostly well formed; some carry a bad header,
    // a bad checksum or get cut short
    task automatic send_frame(input int tick_pct);
        logic [7:0]  frame_bytes[$];
        logic [7:0]  summed[$];
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [15:0] dlen;
        int          flaw;
        int          n;
        int          cut;
        bit          bad_hdr;
        cls = frame_cfg.hdr_class;
        id = frame_cfg.exp_id;
        dlen = {7'd0, frame_cfg.exp_length};
        flaw = $urandom_range(0, 19);
        bad_hdr = (flaw == 14 || flaw == 15);
        if (bad_hdr)
        begin
            case ($urandom_range(0, 2))
                0: cls = cls ^ 8'($urandom_range(1, 255));
                1: id = id ^ 8'($urandom_range(1, 255));
                default: dlen = dlen ^ (16'd1 << $urandom_range(0, 15));
            endcase
        end
        repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(SYNC_FIRST);
        if ($urandom_range(0, 3) == 0)
            frame_bytes.push_back(SYNC_FIRST);
        frame_bytes.push_back(SYNC_SECOND);
        summed.push_back(cls);
        summed.push_back(id);
        summed.push_back(dlen[7:0]);
        summed.push_back(dlen[15:8]);
        if (bad_hdr || dlen > MAX_PAYLOAD)
            n = $urandom_range(0, 2);
        else
            n = dlen;
        repeat (n) summed.push_back(8'($urandom_range(0, 255)));
        ck_a = 8'h00;
        ck_b = 8'h00;
        foreach (summed[i])
        begin
            ck_a = ck_a + summed[i];
            ck_b = ck_b + ck_a;
        end
        if (flaw == 16 || flaw == 17)
        begin
            if ($urandom_range(0, 1) == 0)
                ck_a = ck_a ^ (8'd1 << $urandom_range(0, 7));
            else
                ck_b = ck_b ^ (8'd1 << $urandom_range(0, 7));
        end
        foreach (summed[i])
            frame_bytes.push_back(summed[i]);
        frame_bytes.push_back(ck_a);
        frame_bytes.push_back(ck_b);
        if (flaw >= 18)
        begin
            cut = $urandom_range(0, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        offer_beat(REQ_ARM, 8'($urandom_range(0, 255)), 1'b0, ST_OK);
        foreach (frame_bytes[i])
        begin
            if ($urandom_range(0, 99) < tick_pct)
                offer_beat(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, ST_OK);
            if ($urandom_range(0, 99) == 0)
                offer_beat(REQ_UNUSED, 8'($urandom_range(0, 255)), 1'b0, ST_OK);
            offer_beat(REQ_BYTE, frame_bytes[i], 1'b0, ST_OK);
        end
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t ns: unexpected beat kind %0d data %0d index %0d status %0d",
                         $time, result_kind, data_byte, byte_index, status);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("result_kind", want.kind, result_kind);
                check_field("data_byte", want.data, data_byte);
                check_field("byte_index", want.index, byte_index);
                check_field("status", want.status, status);
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 33);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        directed_row_t script[$];
        cfg_t          c;
        int            tick_pct;
        clear_parser();
        frame_cfg.hdr_class = 8'd1;
        frame_cfg.exp_id = 8'd3;
        frame_cfg.exp_length = 9'd16;
        frame_cfg.timeout_ticks = DEFAULT_TIMEOUT;

        // reset values: class 1, id 3, length 16
        script.push_back(beat_row(REQ_BYTE, SYNC_FIRST));
        script.push_back(beat_row(REQ_TICK, 8'h00));
        script.push_back(beat_row(REQ_UNUSED, 8'hFF));
        script.push_back(beat_row(REQ_ARM, 8'h00));
        script.push_back(beat_row(REQ_BYTE, SYNC_FIRST));
        script.push_back(beat_row(REQ_BYTE, SYNC_FIRST));
        script.push_back(beat_row(REQ_BYTE, SYNC_SECOND));
        script.push_back(beat_row(REQ_BYTE, 8'h01));
        script.push_back(beat_row(REQ_BYTE, 8'h03));
        script.push_back(beat_row(REQ_BYTE, 8'h00));
        script.push_back(done_row(REQ_BYTE, 8'h00, ST_HEADER));
        // zero timeout: first tick ends it
        script.push_back(cfg_row(8'hFF, 8'h00, 9'd0, 16'h0000));
        script.push_back(beat_row(REQ_ARM, 8'hFF));
        script.push_back(beat_row(REQ_UNUSED, 8'h00));
        script.push_back(done_row(REQ_TICK, 8'hFF, ST_TIMEOUT));
        // empty payload after a re-arm while waiting for the second sync byte
        script.push_back(cfg_row(8'hFF, 8'h00, 9'd0, 16'hFFFF));
        script.push_back(beat_row(REQ_ARM, 8'h00));
        script.push_back(beat_row(REQ_BYTE, SYNC_FIRST));
        script.push_back(beat_row(REQ_ARM, 8'h00));
        script.push_back(beat_row(REQ_BYTE, SYNC_FIRST));
        script.push_back(beat_row(REQ_BYTE, SYNC_SECOND));
        script.push_back(beat_row(REQ_BYTE, 8'hFF));
        script.push_back(beat_row(REQ_BYTE, 8'h00));
        script.push_back(beat_row(REQ_BYTE, 8'h00));
        script.push_back(beat_row(REQ_BYTE, 8'h00));
        script.push_back(beat_row(REQ_BYTE, 8'hFF));
        script.push_back(done_row(REQ_BYTE, 8'hFC, ST_OK));
        // length above the payload limit never matches
        script.push_back(cfg_row(8'hFF, 8'h00, 9'd257, 16'hFFFF));
        script.push_back(beat_row(REQ_ARM, 8'h00));
        script.push_back(beat_row(REQ_BYTE, SYNC_FIRST));
        script.push_back(beat_row(REQ_BYTE, SYNC_SECOND));
        script.push_back(beat_row(REQ_BYTE, 8'hFF));
        script.push_back(beat_row(REQ_BYTE, 8'h00));
        script.push_back(beat_row(REQ_BYTE, 8'h01));
        script.push_back(done_row(REQ_BYTE, 8'h01, ST_HEADER));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                settle();
                configure(script[i].cfg);
            end
            else
                offer_beat(script[i].req, script[i].data, script[i].pinned, script[i].st);
        end

        live_items = 0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            c.hdr_class = 8'($urandom_range(0, 255));
            c.exp_id = 8'($urandom_range(0, 255));
            c.timeout_ticks = 16'($urandom_range(200, 65534));
            tick_pct = 2;
            if ($urandom_range(0, 3) == 0)
                c.exp_length = 9'($urandom_range(0, MAX_PAYLOAD));
            else
                c.exp_length = 9'($urandom_range(0, 12));
            case (p)
                0:
                begin
                    c.timeout_ticks = 16'hFFFF;
                    c.exp_length = 9'($urandom_range(0, 12));
                end
                1:
                begin
                    c.hdr_class = 8'h00;
                    c.exp_id = 8'hFF;
                    c.exp_length = 9'(MAX_PAYLOAD);
                    c.timeout_ticks = 16'hFFFF;
                    tick_pct = 0;
                end
                2:
                begin
                    c.exp_length = 9'($urandom_range(0, 8));
                    c.timeout_ticks = 16'($urandom_range(3, 20));
                    tick_pct = 30;
                end
                3:
                begin
                    c.exp_length = 9'($urandom_range(1, 16));
                    c.timeout_ticks = 16'd1;
                    tick_pct = 3;
                end
                4:
                begin
                    c.exp_length = 9'($urandom_range(MAX_PAYLOAD + 1, 511));
                    tick_pct = 5;
                end
                default:
                    tick_pct = 2;
            endcase
            settle();
            calm = (p == 0);
            configure(c);
            if (p == 1)
                hold_request = 1'b1;
            do
                send_frame(tick_pct);
            while (live_items < RANDOM_ITEMS * (p + 1) / RANDOM_PHASES);
        end
        calm = 1'b0;

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
